// ===== sv/d96m_pkg.sv =====
// ----------------------------------------------------------------------------
// d96m_pkg: shared types and constants
// Status codes and the divide-by-ten digit constants of the scaled multiplier.
// ----------------------------------------------------------------------------
package d96m_pkg;

	// result status
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVF_POS = 2'd1,
		ST_OVF_NEG = 2'd2
	} status_t;

	// divide-by-ten is done one 16-bit digit per cycle
	localparam int DIGIT_BITS = 16;
	localparam int REM_BITS   = 4;
	localparam int CUR_BITS   = DIGIT_BITS + REM_BITS;

	// floor(x / 10) == (x * DIV_RECIP) >> DIV_SHIFT for x < 10 * 2**16
	localparam int DIV_RECIP_BITS = 19;
	localparam logic [DIV_RECIP_BITS-1:0] DIV_RECIP = 19'd419431;
	localparam int DIV_SHIFT = 22;

	// operand and result mantissa field width (low word plus high word)
	localparam int FIELD_BITS = 96;

endpackage

// ===== sv/d96m_div10_digit.sv =====
// ----------------------------------------------------------------------------
// d96m_div10_digit: one digit step of a long division by ten
// Takes the running remainder and the next 16-bit digit, gives the quotient
// digit and the new remainder.
// ----------------------------------------------------------------------------
module d96m_div10_digit
	import d96m_pkg::*;
(
	input  logic [REM_BITS-1:0]   rem_in,
	input  logic [DIGIT_BITS-1:0] digit_in,
	output logic [DIGIT_BITS-1:0] quot,
	output logic [REM_BITS-1:0]   rem_out
);

	localparam int PROD_BITS = CUR_BITS + DIV_RECIP_BITS;

	logic [CUR_BITS-1:0]  cur;
	logic [PROD_BITS-1:0] recip_prod;
	logic [CUR_BITS-1:0]  back;

	assign cur        = {rem_in, digit_in};
	assign recip_prod = PROD_BITS'(cur) * PROD_BITS'(DIV_RECIP);
	// cur < 10 * 2**16, so the quotient fits one digit
	assign quot       = recip_prod[DIV_SHIFT +: DIGIT_BITS];
	// q * 10 = q * 8 + q * 2
	assign back       = ({4'd0, quot} << 3) + ({4'd0, quot} << 1);
	assign rem_out    = REM_BITS'(cur - back);

endmodule

// ===== sv/decimal96_multiply.sv =====
// ----------------------------------------------------------------------------
// decimal96_multiply: scaled decimal multiply with divide-by-ten reduction
// Shift-and-add mantissa multiply; unless the product reaches the wide limit, truncating
// divisions by ten follow until the product fits the mantissa or the scale reaches zero.
// ----------------------------------------------------------------------------
// Sequence: one adder pass per multiplier bit, one check, then for each
//   division by ten one step per 16-bit digit of the product (NCH digits,
//   NCH = product width / 16) and a new check, then a finish step that posts
//   the word once the output register is free; k divisions, k <= a_scale + b_scale.
// Throughput: one word in flight; in_ready is high only while idle.
// Reset: arst_n clears the sequencer and the output valid at once.
module decimal96_multiply
	import d96m_pkg::*;
#(
	parameter int MANTISSA_BITS = 96,
	parameter int WIDE_BITS     = 160
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] a_low,
	input  logic [31:0] a_high,
	input  logic [4:0]  a_scale,
	input  logic        a_negative,
	input  logic [63:0] b_low,
	input  logic [31:0] b_high,
	input  logic [4:0]  b_scale,
	input  logic        b_negative,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] r_low,
	output logic [31:0] r_high,
	output logic [5:0]  r_scale,
	output logic        r_negative,
	output logic [1:0]  status
);

	// exact product width, padded to whole 16-bit digits for the divider
	localparam int PW    = 2 * MANTISSA_BITS;
	localparam int NCH   = (PW + DIGIT_BITS - 1) / DIGIT_BITS;
	localparam int PRW   = NCH * DIGIT_BITS;
	localparam int CNT_W = $clog2(MANTISSA_BITS);

	// bits that must be clear for overflow-free and fitting results
	localparam logic [PRW-1:0] WIDE_MASK = {PRW{1'b1}} << WIDE_BITS;
	localparam logic [PRW-1:0] MANT_MASK = {PRW{1'b1}} << MANTISSA_BITS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_CHECK = 5'b00100,
		S_DIV   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [MANTISSA_BITS-1:0] a_q;
	logic [PRW-1:0]           prod_q;
	logic [REM_BITS-1:0]      rem_q;
	logic [5:0]               scale_q;
	logic                     neg_q;
	logic                     fail_q;

	logic                     out_valid_q;
	logic [FIELD_BITS-1:0]    r_mant_q;
	logic [5:0]               r_scale_q;
	logic                     r_neg_q;
	status_t                  status_q;

	// inputs, trimmed or zero-extended to the mantissa width
	logic [FIELD_BITS-1:0]    a_in;
	logic [FIELD_BITS-1:0]    b_in;

	// multiply step: add multiplicand into the upper half, shift right
	logic [MANTISSA_BITS:0]   mul_sum;
	logic [PRW-1:0]           mul_next;

	// divide step: rotate the top digit out, its quotient digit in
	logic [DIGIT_BITS-1:0]    dig_in;
	logic [DIGIT_BITS-1:0]    dig_q;
	logic [REM_BITS-1:0]      dig_rem;
	logic [PRW-1:0]           div_next;

	logic                     any_wide;
	logic                     any_high;
	logic                     out_free;

	assign a_in = {a_high, a_low};
	assign b_in = {b_high, b_low};

	assign mul_sum  = {1'b0, prod_q[PW-1:MANTISSA_BITS]}
	                + (prod_q[0] ? {1'b0, a_q} : {(MANTISSA_BITS + 1){1'b0}});
	assign mul_next = PRW'({mul_sum, prod_q[MANTISSA_BITS-1:1]});

	assign dig_in   = prod_q[PRW-1 -: DIGIT_BITS];
	assign div_next = {prod_q[PRW-DIGIT_BITS-1:0], dig_q};

	d96m_div10_digit u_div10 (
		.rem_in   (rem_q),
		.digit_in (dig_in),
		.quot     (dig_q),
		.rem_out  (dig_rem)
	);

	assign any_wide = |(prod_q & WIDE_MASK);
	assign any_high = |(prod_q & MANT_MASK);
	assign out_free = !out_valid_q || out_ready;

	assign in_ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_MUL;
				end
				S_MUL: begin
					if (cnt_q == CNT_W'(MANTISSA_BITS - 1)) state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!any_wide && any_high && scale_q != 6'd0) state_q <= S_DIV;
					else state_q <= S_FIN;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(NCH - 1)) state_q <= S_CHECK;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					a_q     <= MANTISSA_BITS'(a_in);
					prod_q  <= PRW'(MANTISSA_BITS'(b_in));
					scale_q <= {1'b0, a_scale} + {1'b0, b_scale};
					neg_q   <= a_negative ^ b_negative;
					cnt_q   <= '0;
				end
			end
			S_MUL: begin
				prod_q <= mul_next;
				cnt_q  <= cnt_q + 1'b1;
			end
			S_CHECK: begin
				cnt_q  <= '0;
				rem_q  <= '0;
				fail_q <= any_wide || (any_high && scale_q == 6'd0);
			end
			S_DIV: begin
				prod_q <= div_next;
				rem_q  <= dig_rem;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NCH - 1)) scale_q <= scale_q - 6'd1;
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			if (fail_q) begin
				r_mant_q  <= '0;
				r_scale_q <= '0;
				r_neg_q   <= 1'b0;
				status_q  <= neg_q ? ST_OVF_NEG : ST_OVF_POS;
			end else begin
				r_mant_q  <= FIELD_BITS'(prod_q[MANTISSA_BITS-1:0]);
				r_scale_q <= scale_q;
				r_neg_q   <= neg_q;
				status_q  <= ST_OK;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign r_low      = r_mant_q[63:0];
	assign r_high     = r_mant_q[95:64];
	assign r_scale    = r_scale_q;
	assign r_negative = r_neg_q;
	assign status     = status_q;

	// a failed word carries a zero payload
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK
		|-> r_mant_q == '0 && r_scale_q == 6'd0 && !r_neg_q)
		else $error("failed result with nonzero payload");

	// divisions only run while the scale is positive
	a_div_scale: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> scale_q != 6'd0)
		else $error("division by ten at zero scale");

	// a new output word only comes out of the finish step
	a_post_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("output word posted outside finish step");

endmodule

// ===== tb/sv/decimal96_multiply_tb.sv =====
// ----------------------------------------------------------------------------
// decimal96_multiply_tb: self-checking bench for the scaled decimal multiplier
// Drives operand words through the valid/ready input channel, predicts each
// product with a 192-bit golden computation, and compares every result word
// field by field. Directed corner cases run first, then random words with
// random idling on both channels and one long stretch without idling.
// ----------------------------------------------------------------------------
module decimal96_multiply_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import d96m_pkg::*;

	localparam int MANT = 96;
	localparam int WIDE = 160;
	// worst path: the full multiply plus 62 divisions by ten at most
	localparam int DRAIN_CYCLES = 1000;

	// one operand as it sits on the input ports
	typedef struct packed {
		logic [63:0] low;
		logic [31:0] high;
		logic [4:0]  scale;
		logic        negative;
	} operand_t;

	// one result word as it should appear on the output ports
	typedef struct packed {
		logic [63:0] low;
		logic [31:0] high;
		logic [5:0]  scale;
		logic        negative;
		status_t     status;
	} product_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [63:0] a_low;
	logic [31:0] a_high;
	logic [4:0]  a_scale;
	logic        a_negative;
	logic [63:0] b_low;
	logic [31:0] b_high;
	logic [4:0]  b_scale;
	logic        b_negative;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] r_low;
	logic [31:0] r_high;
	logic [5:0]  r_scale;
	logic        r_negative;
	logic [1:0]  status;

	product_t expected_products[$];
	int       mismatches = 0;
	// set during the no-idling stretch: both sides run flat out
	bit       no_idle = 0;

	decimal96_multiply #(
		.MANTISSA_BITS(MANT),
		.WIDE_BITS    (WIDE)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.a_low     (a_low),
		.a_high    (a_high),
		.a_scale   (a_scale),
		.a_negative(a_negative),
		.b_low     (b_low),
		.b_high    (b_high),
		.b_scale   (b_scale),
		.b_negative(b_negative),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.r_low     (r_low),
		.r_high    (r_high),
		.r_scale   (r_scale),
		.r_negative(r_negative),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Golden product: exact 192-bit multiply, overflow on any bit at or above
	// WIDE, then truncating divisions by ten while the mantissa does not fit
	// and scale remains. A failed word is all zero apart from the status.
	function automatic product_t predict_product(operand_t a, operand_t b);
		logic [191:0] ma;
		logic [191:0] mb;
		logic [191:0] prod;
		int           sc;
		bit           overflow;
		logic         neg;
		product_t     res;
		ma = {96'd0, a.high, a.low};
		mb = {96'd0, b.high, b.low};
		prod = ma * mb;
		sc = int'(a.scale) + int'(b.scale);
		neg = a.negative ^ b.negative;
		overflow = (prod >> WIDE) != 0;
		if (!overflow) begin
			while ((prod >> MANT) != 0 && sc > 0) begin
				prod = prod / 10;
				sc--;
			end
			overflow = (prod >> MANT) != 0;
		end
		if (overflow) begin
			res = '0;
			res.status = neg ? ST_OVF_NEG : ST_OVF_POS;
		end else begin
			res.low = prod[63:0];
			res.high = prod[95:64];
			res.scale = 6'(sc);
			res.negative = neg;
			res.status = ST_OK;
		end
		return res;
	endfunction

	function automatic operand_t mk(logic [63:0] low, logic [31:0] high,
			logic [4:0] scale, logic negative);
		operand_t op;
		op.low = low;
		op.high = high;
		op.scale = scale;
		op.negative = negative;
		return op;
	endfunction

	// Mantissas of assorted lengths so that products land in all three
	// regions: fits directly, needs reduction, overflows outright.
	function automatic operand_t random_operand();
		operand_t    op;
		logic [95:0] m;
		int          pick;
		m = {$urandom, $urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 70)
			m = m >> $urandom_range(96);
		else if (pick < 78)
			m = '1;
		else if (pick < 82)
			m = '0;
		else if (pick < 92)
			m = 96'd1 << $urandom_range(95);
		else
			m = 96'($urandom_range(20));
		op.low = m[63:0];
		op.high = m[95:64];
		pick = $urandom_range(99);
		if (pick < 60)
			op.scale = 5'($urandom_range(28));
		else if (pick < 75)
			op.scale = 5'($urandom_range(31));
		else if (pick < 85)
			op.scale = 5'd0;
		else if (pick < 93)
			op.scale = 5'd28;
		else
			op.scale = 5'($urandom_range(31, 29));
		op.negative = 1'($urandom_range(1));
		return op;
	endfunction

	// Present one operand word and hold it until accepted. Called right after
	// an accepting edge (or reset), so the first falling edge either starts an
	// idle gap or replaces the payload; valid is never dropped and raised in
	// the same step.
	task automatic send_word(operand_t a, operand_t b);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		a_low <= a.low;
		a_high <= a.high;
		a_scale <= a.scale;
		a_negative <= a.negative;
		b_low <= b.low;
		b_high <= b.high;
		b_scale <= b.scale;
		b_negative <= b.negative;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_products.push_back(predict_product(a, b));
	endtask

	// Output side stall: out_ready drops at random, with a chance of about 9 in 100.
	always @(negedge clk)
		out_ready <= no_idle || ($urandom_range(99) >= 9);

	task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result checker: every accepted word is matched to the oldest prediction.
	always @(posedge clk) begin
		product_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_products.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual %h %h %h %h %h",
					$time, r_high, r_low, r_scale, r_negative, status);
				mismatches++;
			end else begin
				want = expected_products.pop_front();
				report_field("r_low", want.low, r_low);
				report_field("r_high", 64'(want.high), 64'(r_high));
				report_field("r_scale", 64'(want.scale), 64'(r_scale));
				report_field("r_negative", 64'(want.negative), 64'(r_negative));
				report_field("status", 64'(want.status), 64'(status));
			end
		end
	end

	// Mantissa and scale extremes.
	task automatic test_extremes();
		send_word(mk('0, '0, 5'd0, 1'b0), mk('0, '0, 5'd0, 1'b0));
		send_word(mk('1, '1, 5'd0, 1'b0), mk(64'd1, '0, 5'd0, 1'b0));
		send_word(mk('1, '1, 5'd31, 1'b1), mk('1, '1, 5'd31, 1'b0));
		send_word(mk(64'd1, '0, 5'd28, 1'b0), mk(64'd1, '0, 5'd28, 1'b0));
		// scales above 28 pass straight through to the result scale
		send_word(mk(64'd7, '0, 5'd31, 1'b1), mk(64'd3, '0, 5'd31, 1'b1));
		send_word(mk('1, '1, 5'd5, 1'b0), mk(64'd1, '0, 5'd0, 1'b0));
		send_word(mk({32{2'b10}}, {16{2'b10}}, 5'd28, 1'b1),
			mk({32{2'b01}}, {16{2'b01}}, 5'd28, 1'b0));
		send_word(mk('1, '0, 5'd15, 1'b0), mk('1, '0, 5'd13, 1'b1));
	endtask

	// Sign handling, including a zero product that keeps the XOR sign.
	task automatic test_signs_and_zero();
		send_word(mk('0, '0, 5'd3, 1'b1), mk('1, '1, 5'd4, 1'b0));
		send_word(mk('0, '0, 5'd0, 1'b1), mk('0, '0, 5'd0, 1'b1));
		send_word(mk(64'd12345, '0, 5'd2, 1'b0), mk(64'd678, '0, 5'd1, 1'b1));
		send_word(mk(64'd12345, '0, 5'd2, 1'b1), mk(64'd678, '0, 5'd1, 1'b1));
	endtask

	// Reduction by ten and both overflow paths.
	task automatic test_reduction_and_overflow();
		// product above the wide limit: overflow, positive and negative
		send_word(mk('1, '1, 5'd28, 1'b0), mk('1, '1, 5'd28, 1'b0));
		send_word(mk('1, '1, 5'd28, 1'b1), mk('1, '1, 5'd28, 1'b0));
		// exactly 2**160 is already too wide
		send_word(mk('0, 32'h8000_0000, 5'd28, 1'b0), mk('0, 32'd2, 5'd28, 1'b0));
		// just under 2**160, reducible with full scale
		send_word(mk('1, '1, 5'd28, 1'b0), mk('0, 32'd1, 5'd28, 1'b1));
		// 2**159 needs many divisions: enough scale, then not enough
		send_word(mk('0, 32'h8000_0000, 5'd28, 1'b0), mk('0, 32'd1, 5'd28, 1'b0));
		send_word(mk('0, 32'h8000_0000, 5'd5, 1'b1), mk('0, 32'd1, 5'd5, 1'b0));
		// one bit too wide: a single division, or overflow with no scale
		send_word(mk('1, '1, 5'd1, 1'b0), mk(64'd2, '0, 5'd0, 1'b0));
		send_word(mk('1, '1, 5'd0, 1'b0), mk(64'd2, '0, 5'd0, 1'b0));
		send_word(mk('1, '1, 5'd0, 1'b1), mk(64'd2, '0, 5'd0, 1'b0));
		// exactly 2**96 with one step of scale
		send_word(mk('0, 32'h8000_0000, 5'd1, 1'b1), mk(64'd2, '0, 5'd0, 1'b1));
	endtask

	task automatic test_random_mix(int count);
		repeat (count)
			send_word(random_operand(), random_operand());
	endtask

	// Back-to-back words with both channels always willing.
	task automatic test_random_no_idling(int count);
		no_idle = 1'b1;
		repeat (count)
			send_word(random_operand(), random_operand());
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		a_low = '0;
		a_high = '0;
		a_scale = '0;
		a_negative = 1'b0;
		b_low = '0;
		b_high = '0;
		b_scale = '0;
		b_negative = 1'b0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_signs_and_zero();
		test_reduction_and_overflow();
		test_random_mix(700);
		test_random_no_idling(300);
		test_random_mix(550);

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_products.size() != 0)
			@(posedge clk);
		// stray words after the last expected one would show up here
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatches == 0 && expected_products.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/d96m_pkg.sv
sv/d96m_div10_digit.sv
sv/decimal96_multiply.sv
tb/sv/decimal96_multiply_tb.sv
